// ===== hdl/assert_macros.svh =====
// assertion helpers included by the top design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, quiet while reset is held
`define PLC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define PLC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/plc_pkg.sv =====
package plc_pkg;

    localparam int NUM_CH = 4;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;
    localparam int QBITS = 8;

    localparam logic [1:0] REG_PTS_LO = 2'd0;
    localparam logic [1:0] REG_PTS_HI = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;
    localparam logic [1:0] REG_MASK = 2'd3;

    // one channel reduced to q = (y1*dx - dy*t) / dx
    typedef struct packed {
        logic [7:0] y1;
        logic [7:0] dx;
        logic signed [8:0] dy;
        logic [7:0] t;
    } chan_t;

    typedef chan_t [NUM_CH-1:0] pix_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic [QUEUE_CNT_W-1:0] count;
    } queue_status_t;

endpackage

// ===== hdl/rgba_piecewise_linear_curve_top.sv =====
// an accepted item passes through the queue, then the multiply stage and 8 divide steps, to its result
// the queue write happens at the accepting edge itself
// throughput: one item per clock while out_stall is low; set by the one-bit-per-stage pipelined divider
// a 4-entry queue parts the classifying front from the arithmetic back
// rst_n is asynchronous, active low: clears the queue, the pipeline valids and config registers
// no clearing pass is needed after reset; input is stalled while reset is held
`include "assert_macros.svh"

module rgba_piecewise_linear_curve_top #(
    parameter int MAX_POINTS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // pixel input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 red_in,
    input  logic [7:0]                 green_in,
    input  logic [7:0]                 blue_in,
    input  logic [7:0]                 alpha_in,
    // pixel output channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 red_out,
    output logic [7:0]                 green_out,
    output logic [7:0]                 blue_out,
    output logic [7:0]                 alpha_out,
    // register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [plc_pkg::ADDR_W-1:0] paddr,
    input  logic [plc_pkg::DATA_W-1:0] pwdata,
    output logic [plc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import plc_pkg::*;

    // configuration registers
    logic [63:0] pts_lo_reg;
    logic [63:0] pts_hi_reg;
    logic [3:0]  count_reg;
    logic [3:0]  mask_reg;
    logic        wr_en;
    logic [1:0]  reg_sel;

    logic [7:0]    pix_in  [NUM_CH];
    logic [7:0]    pix_out [NUM_CH];
    pix_t          pix_cls;
    pix_t          head;
    queue_status_t q_status;
    logic          push;
    logic          pop;
    logic          take;

    // register access: 8-byte spacing, every write completes in its access phase
    assign pready  = 1'b1;
    assign reg_sel = paddr[4:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pts_lo_reg <= '0;
            pts_hi_reg <= '0;
            count_reg  <= '0;
            mask_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_PTS_LO: pts_lo_reg <= pwdata;
                REG_PTS_HI: pts_hi_reg <= pwdata;
                REG_COUNT:  count_reg  <= pwdata[3:0];
                REG_MASK:   mask_reg   <= pwdata[3:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_PTS_LO: prdata = pts_lo_reg;
            REG_PTS_HI: prdata = pts_hi_reg;
            REG_COUNT:  prdata = DATA_W'(count_reg);
            REG_MASK:   prdata = DATA_W'(mask_reg);
            default:    prdata = '0;
        endcase
    end

    // front: pick the segment for each channel as the item arrives
    assign pix_in[0] = red_in;
    assign pix_in[1] = green_in;
    assign pix_in[2] = blue_in;
    assign pix_in[3] = alpha_in;

    plc_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .pts_lo      (pts_lo_reg),
        .pts_hi      (pts_hi_reg),
        .point_count (count_reg),
        .channel_mask(mask_reg),
        .pix_in      (pix_in),
        .pix_cls     (pix_cls)
    );

    // queue: input stalls when all entries are taken or reset is held
    assign in_stall = q_status.full || !rst_n;
    assign push     = in_valid && !q_status.full;
    assign pop      = take && !q_status.empty;

    plc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(pix_cls),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    // back: multiply then restoring division, one quotient bit per stage
    plc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(!q_status.empty),
        .head      (head),
        .take      (take),
        .res_valid (out_valid),
        .res_stall (out_stall),
        .res       (pix_out)
    );

    assign red_out   = pix_out[0];
    assign green_out = pix_out[1];
    assign blue_out  = pix_out[2];
    assign alpha_out = pix_out[3];

    // queue bookkeeping stays consistent
    `PLC_ASSERT(a_queue_bound, q_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue overfilled")
    `PLC_ASSERT(a_queue_flags, !(q_status.full && q_status.empty), "queue full and empty")
    // a stalled result keeps the queue from being read
    `PLC_ASSERT(a_pop_pipe, (out_valid && out_stall) |-> !pop, "queue read while back is stalled")
    // count rises by one on a push without a pop
    `PLC_ASSERT(a_count_step, (push && !pop) |=> (q_status.count == $past(q_status.count) + 1'b1), "queue count slip")

endmodule

// ===== hdl/plc_front.sv =====
module plc_front #(
    parameter int MAX_POINTS = 8
) (
    input  logic [63:0]       pts_lo,
    input  logic [63:0]       pts_hi,
    input  logic [3:0]        point_count,
    input  logic [3:0]        channel_mask,
    input  logic [7:0]        pix_in [plc_pkg::NUM_CH],
    output plc_pkg::pix_t     pix_cls
);
    import plc_pkg::*;

    localparam logic [3:0] MAX_N = 4'(MAX_POINTS);

    logic [127:0] pts_all;
    logic [3:0]   n_used;
    logic [7:0]   px [MAX_POINTS];
    logic [7:0]   py [MAX_POINTS];

    assign pts_all = {pts_hi, pts_lo};
    assign n_used  = (point_count > MAX_N) ? MAX_N : point_count;

    genvar k;
    generate
        for (k = 0; k < MAX_POINTS; k++)
        begin : g_pt
            assign px[k] = pts_all[16*k +: 8];
            assign py[k] = pts_all[16*k+8 +: 8];
        end
    endgenerate

    // per channel: first matching segment wins, so scan from the top down
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            pix_cls[c].dx = 8'd1;
            pix_cls[c].dy = 9'sd0;
            pix_cls[c].t  = 8'd0;
            pix_cls[c].y1 = channel_mask[c] ? 8'd0 : pix_in[c];
            if (channel_mask[c])
            begin
                for (int i = MAX_POINTS - 1; i >= 1; i--)
                begin
                    if ((4'(i) < n_used) && (pix_in[c] > px[i-1]) && (pix_in[c] <= px[i]))
                    begin
                        pix_cls[c].y1 = py[i];
                        pix_cls[c].dx = px[i] - px[i-1];
                        pix_cls[c].dy = $signed({1'b0, py[i]}) - $signed({1'b0, py[i-1]});
                        pix_cls[c].t  = px[i] - pix_in[c];
                    end
                end
            end
        end
    end

endmodule

// ===== hdl/plc_queue.sv =====
module plc_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  plc_pkg::pix_t          push_data,
    input  logic                   pop,
    output plc_pkg::pix_t          head,
    output plc_pkg::queue_status_t status
);
    import plc_pkg::*;

    pix_t                   mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head         = mem[rd_ptr_reg];
    assign status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

endmodule

// ===== hdl/plc_back.sv =====
module plc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  plc_pkg::pix_t head,
    output logic          take,
    output logic          res_valid,
    input  logic          res_stall,
    output logic [7:0]    res [plc_pkg::NUM_CH]
);
    import plc_pkg::*;

    // stage 0 holds the numerator, stages 1..QBITS one quotient bit each
    logic                vld_reg  [QBITS+1];
    logic [15:0]         rem_reg  [QBITS+1][NUM_CH];
    logic [7:0]          dx_reg   [QBITS+1][NUM_CH];
    logic [QBITS-1:0]    quo_reg  [QBITS+1][NUM_CH];
    logic                adv;

    assign adv  = !vld_reg[QBITS] || !res_stall;
    assign take = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= QBITS; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= head_valid;
            for (int s = 1; s <= QBITS; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                logic signed [18:0] num;
                num = 19'($signed({1'b0, head[c].y1}) * $signed({1'b0, head[c].dx}))
                    - 19'(head[c].dy * $signed({1'b0, head[c].t}));
                rem_reg[0][c] <= num[15:0];
                dx_reg[0][c]  <= head[c].dx;
                quo_reg[0][c] <= '0;
            end
            for (int s = 1; s <= QBITS; s++)
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    logic [15:0] dsh;
                    dsh = 16'(dx_reg[s-1][c]) << (QBITS - s);
                    dx_reg[s][c] <= dx_reg[s-1][c];
                    if (rem_reg[s-1][c] >= dsh)
                    begin
                        rem_reg[s][c] <= rem_reg[s-1][c] - dsh;
                        quo_reg[s][c] <= quo_reg[s-1][c] | (QBITS'(1) << (QBITS - s));
                    end
                    else
                    begin
                        rem_reg[s][c] <= rem_reg[s-1][c];
                        quo_reg[s][c] <= quo_reg[s-1][c];
                    end
                end
            end
        end
    end

    assign res_valid = vld_reg[QBITS];

    genvar g;
    generate
        for (g = 0; g < NUM_CH; g++)
        begin : g_res
            assign res[g] = quo_reg[QBITS][g];
        end
    endgenerate

endmodule
